// ===== design/wrrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrs_pkg
// Shared types and constants of the weighted round-robin scheduler.
// ----------------------------------------------------------------------------
package wrrs_pkg;

	// field widths fixed by the interface
	localparam int READY_W  = 8;
	localparam int SLOT_IDX_W = 3;
	localparam int ACTIVE_W = 4;
	localparam int TABLE_W  = 64;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_SLOTS = 2'd0,
		REG_WEIGHT_TABLE = 2'd1
	} reg_idx_t;

	// controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming ready mask
		logic exec;     // run the grant search and load the result
	} dp_cmd_t;

endpackage

// ===== design/weighted_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler
// Grants one ready slot per tick by weighted round robin.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, ready_mask) carries one tick request:
//   the mask of slots that may run. Output channel (out_valid/out_ready,
//   granted, slot_index) returns one result per request: the granted slot,
//   or granted low and slot_index zero when nothing is eligible.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; index 0 sets active_slots, index 1 writes the weight table and
//   reloads all run counters. Write only while no request is in flight.
//   Each request is latched in the intake state, then the exec state runs
//   the grant search and counter update and loads the result register;
//   no new request is taken until that result is loaded.
//   The next request is taken while a result waits; if out_ready stays low
//   the block holds that request in its search state until the result
//   register drains.
//   Reset: weights, counters, active count and slot pointer clear to zero,
//   no result pending.
// ----------------------------------------------------------------------------
module weighted_round_robin_scheduler import wrrs_pkg::*; #(
	parameter int NUM_SLOTS   = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [READY_W-1:0]    ready_mask,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  granted,
	output logic [SLOT_IDX_W-1:0] slot_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TABLE_W-1:0]    cfg_data
);

	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// controller
	wrrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath
	wrrs_dp #(
		.NUM_SLOTS   (NUM_SLOTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ready_mask (ready_mask),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.granted    (granted),
		.slot_index (slot_index)
	);

endmodule

// ===== design/wrrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrs_ctrl
// Sequencer for request intake, grant evaluation and result handshake.
// ----------------------------------------------------------------------------
module wrrs_ctrl import wrrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// result register can load a new result this cycle
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = out_free;
			end
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/wrrs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrs_dp
// Config registers, run counters, slot pointer and the rotating grant search.
// ----------------------------------------------------------------------------
module wrrs_dp import wrrs_pkg::*; #(
	parameter int NUM_SLOTS   = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [READY_W-1:0]    ready_mask,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [TABLE_W-1:0]    cfg_data,
	output logic                  granted,
	output logic [SLOT_IDX_W-1:0] slot_index
);

	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int TBL_SLOTS  = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
	localparam logic [4:0] NUM_SLOTS_5 = 5'(NUM_SLOTS);

	logic [ACTIVE_W-1:0]    active_q;
	logic [TABLE_W-1:0]     wtable_q;
	logic [READY_W-1:0]     ready_q;
	logic [SLOT_W-1:0]      cur_q;
	logic [WEIGHT_BITS-1:0] cnt_q [NUM_SLOTS];
	logic                   granted_q;
	logic [SLOT_IDX_W-1:0]  slot_q;

	logic [WEIGHT_BITS-1:0] weight [NUM_SLOTS];
	logic [4:0]             act5;
	logic [4:0]             n5;
	logic [SLOT_W-1:0]      pos;
	logic [NUM_SLOTS-1:0]   elig;
	logic [NUM_SLOTS-1:0]   nz;
	logic [NUM_SLOTS-1:0]   cand;
	logic [NUM_SLOTS-1:0]   ge_pos;
	logic [NUM_SLOTS-1:0]   lt_g;
	logic [NUM_SLOTS-1:0]   span;
	logic [NUM_SLOTS-1:0]   refill;
	logic [NUM_SLOTS-1:0]   srch;
	logic [NUM_SLOTS-1:0]   srch_hi;
	logic                   hit;
	logic [SLOT_W-1:0]      g;

	// lowest set bit of a slot mask
	function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] m);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (m[i]) idx = SLOT_W'(i);
		end
		return idx;
	endfunction

	// per-slot weights, slots beyond the table weigh zero
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) weight[i] = '0;
		for (int i = 0; i < TBL_SLOTS; i++) weight[i] = wtable_q[8*i +: WEIGHT_BITS];
	end

	// active count clamp and start position
	assign act5 = {1'b0, active_q};
	assign n5   = (act5 > NUM_SLOTS_5) ? NUM_SLOTS_5 : act5;
	assign pos  = (5'(cur_q) < n5) ? cur_q : '0;

	// eligible and nonzero-counter masks
	always_comb begin
		elig   = '0;
		nz     = '0;
		ge_pos = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			nz[i]     = (cnt_q[i] != '0);
			ge_pos[i] = (SLOT_W'(i) >= pos);
		end
		for (int i = 0; i < TBL_SLOTS; i++) begin
			elig[i] = (5'(i) < n5) && ready_q[i] && (weight[i] != '0);
		end
	end

	// rotating search: counters with credit first, else any eligible slot
	assign cand    = elig & nz;
	assign hit     = |cand;
	assign srch    = hit ? cand : elig;
	assign srch_hi = srch & ge_pos;
	assign g       = (|srch_hi) ? first_set(srch_hi) : first_set(srch);

	// empty counters passed over before the granted slot get refilled; with no credit left, all eligible ones
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) lt_g[i] = (SLOT_W'(i) < g);
		span   = (g >= pos) ? (ge_pos & lt_g) : (ge_pos | lt_g);
		refill = hit ? (elig & ~nz & span) : elig;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			wtable_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ACTIVE_SLOTS) active_q <= cfg_data[ACTIVE_W-1:0];
			if (cfg_index == REG_WEIGHT_TABLE) wtable_q <= cfg_data;
		end
	end

	// latched ready mask of the pending request
	always_ff @(posedge clk) begin
		if (cmd.capture) ready_q <= ready_mask;
	end

	// run counters and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) cnt_q[i] <= '0;
		end else if (cfg_we && cfg_index == REG_WEIGHT_TABLE) begin
			// new table reloads every counter
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (i < TBL_SLOTS) cnt_q[i] <= cfg_data[8*(i%8) +: WEIGHT_BITS];
				else cnt_q[i] <= '0;
			end
		end else if (cmd.exec && (|elig)) begin
			cur_q <= g;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (SLOT_W'(i) == g) begin
					if (hit) cnt_q[i] <= cnt_q[i] - WEIGHT_BITS'(1);
					else cnt_q[i] <= weight[i] - WEIGHT_BITS'(1);
				end else if (refill[i]) begin
					cnt_q[i] <= weight[i];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granted_q <= 1'b0;
			slot_q    <= '0;
		end else if (cmd.exec) begin
			granted_q <= |elig;
			slot_q    <= (|elig) ? SLOT_IDX_W'(g) : '0;
		end
	end

	assign granted    = granted_q;
	assign slot_index = slot_q;

endmodule

// ===== sim/tb_weighted_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_round_robin_scheduler
// Self-checking bench for the weighted round-robin slot scheduler: a
// directed pass over zero weights, inactive and out-of-range slots, stale
// pointers and counter refill laps, then random weight tables and ready
// masks, all checked against a cycle-free grant predictor.
// ----------------------------------------------------------------------------
module tb_weighted_round_robin_scheduler;
	import wrrs_pkg::*;

	localparam int SLOTS = 8;
	localparam int WBITS = 8;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 115;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic                  granted;
		logic [SLOT_IDX_W-1:0] slot;
	} grant_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [READY_W-1:0]    ready_mask = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  granted;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_ACTIVE_SLOTS;
	logic [TABLE_W-1:0]    cfg_data = '0;

	// predictor state, mirrors the block after reset
	logic [ACTIVE_W-1:0]   act_slots = '0;
	logic [TABLE_W-1:0]    wtab = '0;
	logic [WBITS-1:0]      run_cnt [SLOTS];
	logic [SLOT_IDX_W-1:0] cur_slot = '0;

	logic [READY_W-1:0] pend_masks [$];
	grant_t             grant_q [$];
	int                 err_cnt = 0;
	bit                 req_fired = 1'b0;
	bit                 hold_req = 1'b0;

	weighted_round_robin_scheduler #(
		.NUM_SLOTS  (SLOTS),
		.WEIGHT_BITS(WBITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ready_mask(ready_mask),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.granted   (granted),
		.slot_index(slot_index),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) run_cnt[i] = '0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic logic [WBITS-1:0] slot_wt(input int idx);
		if (idx >= 8) return '0;
		return wtab[8*idx +: WBITS];
	endfunction

	// weighted walk from the pointer, refilling empty counters it passes
	function automatic void predict_grant(input logic [READY_W-1:0] mask,
	                                      output grant_t res);
		int n;
		int pos;
		int i;
		int k;
		logic [SLOTS-1:0] elig;
		res = '0;
		n = (act_slots > SLOTS) ? SLOTS : int'(act_slots);
		elig = '0;
		for (i = 0; i < n; i++) begin
			if (mask[i] && slot_wt(i) != 0) elig[i] = 1'b1;
		end
		if (elig == '0) return;
		pos = (cur_slot < n) ? int'(cur_slot) : 0;
		for (k = 0; k < 2 * n; k++) begin
			if (elig[pos]) begin
				if (run_cnt[pos] != 0) begin
					run_cnt[pos] = run_cnt[pos] - WBITS'(1);
					cur_slot = SLOT_IDX_W'(pos);
					res.granted = 1'b1;
					res.slot = SLOT_IDX_W'(pos);
					return;
				end
				run_cnt[pos] = slot_wt(pos);
			end
			pos = (pos + 1 >= n) ? 0 : pos + 1;
		end
	endfunction

	// register write, predictor updated at the accepting edge
	task automatic cfg_write(input reg_idx_t idx, input logic [TABLE_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ACTIVE_SLOTS: act_slots = val[ACTIVE_W-1:0];
			REG_WEIGHT_TABLE: begin
				wtab = val;
				for (int i = 0; i < SLOTS; i++) run_cnt[i] = slot_wt(i);
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// block until every queued request is taken and answered
	task automatic wait_idle();
		while (pend_masks.size() != 0 || in_valid || grant_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ACTIVE_W-1:0] rand_active();
		case ($urandom_range(11))
			0: return '0;
			1, 2: return ACTIVE_W'($urandom_range(15, 9));
			3, 4, 5: return ACTIVE_W'(SLOTS);
			default: return ACTIVE_W'($urandom_range(8, 1));
		endcase
	endfunction

	function automatic logic [TABLE_W-1:0] rand_table();
		logic [TABLE_W-1:0] t;
		if ($urandom_range(3) == 0) return {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(7))
				0: t[8*i +: 8] = 8'h00;
				1: t[8*i +: 8] = 8'h01;
				2: t[8*i +: 8] = 8'hFF;
				default: t[8*i +: 8] = 8'($urandom_range(6, 1));
			endcase
		end
		return t;
	endfunction

	function automatic logic [READY_W-1:0] rand_mask();
		case ($urandom_range(9))
			0: return '1;
			1: return READY_W'(1) << $urandom_range(READY_W - 1);
			2: return '0;
			default: return READY_W'($urandom);
		endcase
	endfunction

	// request driver, bursts with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_fired)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pend_masks.size() != 0) begin
				in_valid   <= 1'b1;
				ready_mask <= pend_masks.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(40, 1);
					gap_left = ($urandom_range(9) < 4) ? 0 : $urandom_range(6, 1);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, duty cycle changes per stretch, plus one long hold
	int hold_left = 0;
	int pat_left = 0;
	int pat_pct = 100;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(96, 16);
				case ($urandom_range(3))
					0: pat_pct = 100;
					1: pat_pct = 75;
					2: pat_pct = 50;
					default: pat_pct = 20;
				endcase
			end
			pat_left--;
			out_ready <= ($urandom_range(99) < pat_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin : mon
		grant_t got;
		grant_t want;
		req_fired = arst_n && in_valid && in_ready;
		if (req_fired) begin
			predict_grant(ready_mask, want);
			grant_q.push_back(want);
		end
		if (arst_n && out_valid && out_ready) begin
			got = '{granted: granted, slot: slot_index};
			if (grant_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result granted=%0b slot=%0d",
				                          granted, slot_index));
			end else begin
				want = grant_q.pop_front();
				if (got.granted !== want.granted)
					report_mismatch($sformatf("granted got %0b want %0b",
					                          got.granted, want.granted));
				if (got.slot !== want.slot)
					report_mismatch($sformatf("slot_index got %0d want %0d",
					                          got.slot, want.slot));
			end
		end
	end

	// run limit
	initial begin
		#3_000_000;
		$display("tb_weighted_round_robin_scheduler: FAIL");
		$finish;
	end

	// stimulus sequence
	initial begin : stim
		int guard;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: nothing active, every slot idles
		pend_masks = '{8'h00, 8'hFF};
		wait_idle();

		// mixed weights, slot 2 carries zero weight
		cfg_write(REG_WEIGHT_TABLE, 64'h02_04_01_FF_03_00_02_01);
		cfg_write(REG_ACTIVE_SLOTS, 64'd8);
		pend_masks = '{8'hFF, 8'hFF, 8'h04, 8'h00, 8'h80, 8'h80, 8'h80,
		               8'h01, 8'h01, 8'hAA, 8'h55};
		wait_idle();

		// pointer now beyond the active count, upper slots ignored
		cfg_write(REG_ACTIVE_SLOTS, 64'd3);
		pend_masks = '{8'hFF, 8'hF8, 8'h07};
		wait_idle();

		// active count above the slot count
		cfg_write(REG_ACTIVE_SLOTS, 64'd15);
		pend_masks = '{8'hFF, 8'h80};
		wait_idle();

		// full weights
		cfg_write(REG_WEIGHT_TABLE, '1);
		pend_masks = '{8'hFF};
		wait_idle();

		// single slot of weight one: refill lap on every tick after the first
		cfg_write(REG_WEIGHT_TABLE, 64'h01_01_01_01_01_01_01_01);
		cfg_write(REG_ACTIVE_SLOTS, 64'd1);
		pend_masks = '{8'h01, 8'h01, 8'h01};
		wait_idle();

		// all weights zero
		cfg_write(REG_WEIGHT_TABLE, '0);
		cfg_write(REG_ACTIVE_SLOTS, 64'd8);
		pend_masks = '{8'hFF};
		wait_idle();

		// random phases, registers rewritten in random order
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if ($urandom_range(1)) begin
				cfg_write(REG_WEIGHT_TABLE, rand_table());
				cfg_write(REG_ACTIVE_SLOTS, TABLE_W'(rand_active()));
			end else begin
				cfg_write(REG_ACTIVE_SLOTS, TABLE_W'(rand_active()));
				cfg_write(REG_WEIGHT_TABLE, rand_table());
			end
			for (int i = 0; i < PHASE_ITEMS; i++) pend_masks.push_back(rand_mask());
			if (ph == 3) hold_req = 1'b1;
			wait_idle();
		end

		// drain with a bound, then look for anything left over
		guard = 0;
		while (grant_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (grant_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", grant_q.size()));

		if (err_cnt == 0) begin
			$display("tb_weighted_round_robin_scheduler: PASS");
		end else begin
			$display("tb_weighted_round_robin_scheduler: FAIL");
		end
		$finish;
	end

endmodule
